/* sv/brst_pkg.sv */
// ----------------------------------------------------------------------------
// brst_pkg: shared types and constants for the block range sum table
// Field widths, default geometry, operation codes, state machine encodings
// and the control word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package brst_pkg;

    // fixed field widths
    localparam int POS_W = 10;
    localparam int VAL_W = 32;
    localparam int SUM_W = 42;

    // default table geometry
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_BLOCK_SIZE  = 32;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // operation codes
    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_QUO,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_SET_RD,
        B_SET_WR,
        B_WALK,
        B_DRAIN,
        B_OUT
    } back_state_t;

    // classification of one queued command
    typedef struct packed {
        logic is_query;
        logic empty;
    } cmd_ctl_t;

endpackage

/* sv/brst_front.sv */
// ----------------------------------------------------------------------------
// brst_front: input front end
// Takes one input beat, finds the block and offset of the position with a
// reciprocal multiply, clamps the query end, flags empty ranges, drops sets
// beyond the table and pushes a command into the queue.
// ----------------------------------------------------------------------------
module brst_front #(
    parameter int TABLE_DEPTH = brst_pkg::DEF_TABLE_DEPTH,
    parameter int BLOCK_SIZE  = brst_pkg::DEF_BLOCK_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                enable,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                operation,
    input  logic [brst_pkg::POS_W-1:0]          position,
    input  logic [brst_pkg::POS_W-1:0]          range_end,
    input  logic signed [brst_pkg::VAL_W-1:0]   new_value,
    output logic                                push_valid,
    input  logic                                push_ready,
    output brst_pkg::cmd_ctl_t                  push_ctl,
    output logic [$clog2(TABLE_DEPTH)-1:0]      push_idx,
    output logic [$clog2(TABLE_DEPTH)-1:0]      push_hi,
    output logic [((TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE > 1 ?
                   $clog2((TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE) : 1)-1:0] push_blk,
    output logic [$clog2(BLOCK_SIZE)-1:0]       push_off,
    output logic signed [brst_pkg::VAL_W-1:0]   push_value
);

    localparam int POS_W      = brst_pkg::POS_W;
    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int NUM_BLOCKS = (TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OFF_W      = $clog2(BLOCK_SIZE);
    // exact quotient for any POS_W-bit dividend: q = (x * RECIP) >> SHIFT
    localparam int SHIFT      = POS_W + $clog2(BLOCK_SIZE);
    localparam int RECIP      = ((1 << SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int RECIP_W    = POS_W + 2;
    localparam int PROD_W     = POS_W + RECIP_W;

    brst_pkg::front_state_t state_reg, state_next;

    logic                        op_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            end_reg;
    logic signed [brst_pkg::VAL_W-1:0] value_reg;
    logic [PROD_W-1:0]           prod_reg, prod_next;
    logic [POS_W-1:0]            quo_reg, quo_next;

    logic                        accept;
    logic                        set_oob;
    logic [IDX_W-1:0]            hi_clamp;
    logic                        empty_range;
    int                          rem;

    assign accept = item_valid && item_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brst_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // captured beat and divider pipeline
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            pos_reg   <= position;
            end_reg   <= range_end;
            value_reg <= new_value;
        end
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
    end

    // classification of the held beat
    always_comb
    begin
        set_oob     = int'(pos_reg) >= TABLE_DEPTH;
        hi_clamp    = (int'(end_reg) >= TABLE_DEPTH) ? IDX_W'(TABLE_DEPTH - 1)
                                                     : IDX_W'(end_reg);
        empty_range = int'(pos_reg) > int'(hi_clamp);
        rem         = int'(pos_reg) - int'(quo_reg) * BLOCK_SIZE;
    end

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        push_valid = 1'b0;
        prod_next  = prod_reg;
        quo_next   = quo_reg;
        case (state_reg)
            brst_pkg::F_IDLE:
            begin
                item_ready = enable;
                if (accept)
                begin
                    state_next = brst_pkg::F_MUL;
                end
            end
            brst_pkg::F_MUL:
            begin
                prod_next  = PROD_W'(pos_reg) * PROD_W'(RECIP);
                state_next = brst_pkg::F_QUO;
            end
            brst_pkg::F_QUO:
            begin
                quo_next   = POS_W'(prod_reg >> SHIFT);
                state_next = brst_pkg::F_PUSH;
            end
            brst_pkg::F_PUSH:
            begin
                // a set beyond the table is dropped
                if (op_reg == brst_pkg::OP_SET && set_oob)
                begin
                    state_next = brst_pkg::F_IDLE;
                end
                else
                begin
                    push_valid = 1'b1;
                    if (push_ready)
                    begin
                        state_next = brst_pkg::F_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = brst_pkg::F_IDLE;
            end
        endcase
    end

    // command payload
    always_comb
    begin
        push_ctl.is_query = (op_reg == brst_pkg::OP_QUERY);
        push_ctl.empty    = empty_range;
        push_idx          = IDX_W'(pos_reg);
        push_hi           = hi_clamp;
        push_blk          = BLK_W'(quo_reg);
        push_off          = OFF_W'(rem);
        push_value        = value_reg;
    end

endmodule

/* sv/brst_queue.sv */
// ----------------------------------------------------------------------------
// brst_queue: command queue
// Short first-in first-out store of classified commands so that the front
// end and the back end stall on their own.
// ----------------------------------------------------------------------------
module brst_queue #(
    parameter int TABLE_DEPTH = brst_pkg::DEF_TABLE_DEPTH,
    parameter int BLOCK_SIZE  = brst_pkg::DEF_BLOCK_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push_valid,
    output logic                                push_ready,
    input  brst_pkg::cmd_ctl_t                  push_ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      push_idx,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      push_hi,
    input  logic [((TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE > 1 ?
                   $clog2((TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE) : 1)-1:0] push_blk,
    input  logic [$clog2(BLOCK_SIZE)-1:0]       push_off,
    input  logic signed [brst_pkg::VAL_W-1:0]   push_value,
    output logic                                pop_valid,
    input  logic                                pop_ready,
    output brst_pkg::cmd_ctl_t                  pop_ctl,
    output logic [$clog2(TABLE_DEPTH)-1:0]      pop_idx,
    output logic [$clog2(TABLE_DEPTH)-1:0]      pop_hi,
    output logic [((TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE > 1 ?
                   $clog2((TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE) : 1)-1:0] pop_blk,
    output logic [$clog2(BLOCK_SIZE)-1:0]       pop_off,
    output logic signed [brst_pkg::VAL_W-1:0]   pop_value
);

    localparam int DEPTH      = brst_pkg::QUEUE_DEPTH;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int NUM_BLOCKS = (TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OFF_W      = $clog2(BLOCK_SIZE);

    brst_pkg::cmd_ctl_t          ctl_q   [DEPTH];
    logic [IDX_W-1:0]            idx_q   [DEPTH];
    logic [IDX_W-1:0]            hi_q    [DEPTH];
    logic [BLK_W-1:0]            blk_q   [DEPTH];
    logic [OFF_W-1:0]            off_q   [DEPTH];
    logic signed [brst_pkg::VAL_W-1:0] value_q [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (int'(count_reg) < DEPTH);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctl_q[wr_ptr_reg]   <= push_ctl;
            idx_q[wr_ptr_reg]   <= push_idx;
            hi_q[wr_ptr_reg]    <= push_hi;
            blk_q[wr_ptr_reg]   <= push_blk;
            off_q[wr_ptr_reg]   <= push_off;
            value_q[wr_ptr_reg] <= push_value;
        end
    end

    // head entry
    always_comb
    begin
        pop_ctl   = ctl_q[rd_ptr_reg];
        pop_idx   = idx_q[rd_ptr_reg];
        pop_hi    = hi_q[rd_ptr_reg];
        pop_blk   = blk_q[rd_ptr_reg];
        pop_off   = off_q[rd_ptr_reg];
        pop_value = value_q[rd_ptr_reg];
    end

endmodule

/* sv/brst_back.sv */
// ----------------------------------------------------------------------------
// brst_back: execution back end
// Owns the element memory and the block sum memory. Clears both after reset,
// applies sets as read-modify-write, walks query ranges one memory read per
// cycle and holds the finished sum in the output register.
// ----------------------------------------------------------------------------
module brst_back #(
    parameter int TABLE_DEPTH = brst_pkg::DEF_TABLE_DEPTH,
    parameter int BLOCK_SIZE  = brst_pkg::DEF_BLOCK_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    output logic                                clear_done,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  brst_pkg::cmd_ctl_t                  pop_ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      pop_idx,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      pop_hi,
    input  logic [((TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE > 1 ?
                   $clog2((TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE) : 1)-1:0] pop_blk,
    input  logic [$clog2(BLOCK_SIZE)-1:0]       pop_off,
    input  logic signed [brst_pkg::VAL_W-1:0]   pop_value,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [brst_pkg::SUM_W-1:0]   range_sum
);

    localparam int VAL_W      = brst_pkg::VAL_W;
    localparam int SUM_W      = brst_pkg::SUM_W;
    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int NUM_BLOCKS = (TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OFF_W      = $clog2(BLOCK_SIZE);

    // memories
    logic [VAL_W-1:0] elem_mem [TABLE_DEPTH];
    logic [SUM_W-1:0] blk_mem  [NUM_BLOCKS];
    logic [VAL_W-1:0] elem_rd_reg;
    logic [SUM_W-1:0] blk_rd_reg;

    logic             elem_we, elem_re, blk_we, blk_re;
    logic [IDX_W-1:0] elem_waddr, elem_raddr;
    logic [BLK_W-1:0] blk_waddr, blk_raddr;
    logic [VAL_W-1:0] elem_wdata;
    logic [SUM_W-1:0] blk_wdata;

    brst_pkg::back_state_t state_reg, state_next;

    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic             pend_reg, pend_next;
    logic             pend_blk_reg, pend_blk_next;
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] out_sum_reg, out_sum_next;

    logic [SUM_W-1:0] elem_rd_ext;
    logic [SUM_W-1:0] value_ext;
    logic [SUM_W-1:0] pend_term;
    logic [IDX_W-1:0] span;
    logic             whole_block;

    assign result_valid = out_valid_reg;
    assign range_sum    = out_sum_reg;
    assign clear_done   = (state_reg != brst_pkg::B_CLEAR);

    // element memory port
    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re)
        begin
            elem_rd_reg <= elem_mem[elem_raddr];
        end
    end

    // block sum memory port
    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        if (blk_re)
        begin
            blk_rd_reg <= blk_mem[blk_raddr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brst_pkg::B_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        hi_reg       <= hi_next;
        blk_reg      <= blk_next;
        off_reg      <= off_next;
        value_reg    <= value_next;
        acc_reg      <= acc_next;
        pend_blk_reg <= pend_blk_next;
        out_sum_reg  <= out_sum_next;
    end

    // sign extension and walk decisions
    always_comb
    begin
        elem_rd_ext = {{(SUM_W - VAL_W){elem_rd_reg[VAL_W-1]}}, elem_rd_reg};
        value_ext   = {{(SUM_W - VAL_W){value_reg[VAL_W-1]}}, value_reg};
        pend_term   = pend_blk_reg ? blk_rd_reg : elem_rd_ext;
        span        = hi_reg - i_reg;
        whole_block = (off_reg == '0) && (int'(span) >= BLOCK_SIZE - 1);
    end

    // next state, memory control and output register
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        i_next         = i_reg;
        hi_next        = hi_reg;
        blk_next       = blk_reg;
        off_next       = off_reg;
        value_next     = value_reg;
        acc_next       = acc_reg;
        pend_next      = 1'b0;
        pend_blk_next  = pend_blk_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_sum_next   = out_sum_reg;
        pop_ready      = 1'b0;

        elem_we    = 1'b0;
        elem_waddr = i_reg;
        elem_wdata = value_reg;
        elem_re    = 1'b0;
        elem_raddr = i_reg;
        blk_we     = 1'b0;
        blk_waddr  = blk_reg;
        blk_wdata  = blk_rd_reg - elem_rd_ext + value_ext;
        blk_re     = 1'b0;
        blk_raddr  = blk_reg;

        // retire the read issued last cycle
        if (pend_reg)
        begin
            acc_next = acc_reg + pend_term;
        end

        case (state_reg)
            brst_pkg::B_CLEAR:
            begin
                elem_we    = 1'b1;
                elem_waddr = clr_reg;
                elem_wdata = '0;
                blk_we     = (int'(clr_reg) < NUM_BLOCKS);
                blk_waddr  = BLK_W'(clr_reg);
                blk_wdata  = '0;
                clr_next   = clr_reg + 1'b1;
                if (int'(clr_reg) == TABLE_DEPTH - 1)
                begin
                    state_next = brst_pkg::B_IDLE;
                end
            end
            brst_pkg::B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    i_next     = pop_idx;
                    hi_next    = pop_hi;
                    blk_next   = pop_blk;
                    off_next   = pop_off;
                    value_next = pop_value;
                    acc_next   = '0;
                    if (!pop_ctl.is_query)
                    begin
                        state_next = brst_pkg::B_SET_RD;
                    end
                    else if (pop_ctl.empty)
                    begin
                        state_next = brst_pkg::B_OUT;
                    end
                    else
                    begin
                        state_next = brst_pkg::B_WALK;
                    end
                end
            end
            brst_pkg::B_SET_RD:
            begin
                elem_re    = 1'b1;
                blk_re     = 1'b1;
                state_next = brst_pkg::B_SET_WR;
            end
            brst_pkg::B_SET_WR:
            begin
                elem_we    = 1'b1;
                blk_we     = 1'b1;
                state_next = brst_pkg::B_IDLE;
            end
            brst_pkg::B_WALK:
            begin
                pend_next     = 1'b1;
                pend_blk_next = whole_block;
                if (whole_block)
                begin
                    blk_re   = 1'b1;
                    i_next   = i_reg + IDX_W'(BLOCK_SIZE);
                    blk_next = blk_reg + 1'b1;
                    if (int'(span) == BLOCK_SIZE - 1)
                    begin
                        state_next = brst_pkg::B_DRAIN;
                    end
                end
                else
                begin
                    elem_re = 1'b1;
                    i_next  = i_reg + 1'b1;
                    if (int'(off_reg) == BLOCK_SIZE - 1)
                    begin
                        off_next = '0;
                        blk_next = blk_reg + 1'b1;
                    end
                    else
                    begin
                        off_next = off_reg + 1'b1;
                    end
                    if (i_reg == hi_reg)
                    begin
                        state_next = brst_pkg::B_DRAIN;
                    end
                end
            end
            brst_pkg::B_DRAIN:
            begin
                state_next = brst_pkg::B_OUT;
            end
            brst_pkg::B_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_reg;
                    state_next     = brst_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = brst_pkg::B_IDLE;
            end
        endcase
    end

endmodule

/* sv/block_range_sum_table.sv */
// ----------------------------------------------------------------------------
// block_range_sum_table: table of signed elements with per-block sums
// Set beats write one element and update its block sum; query beats return
// the wrapped sum over an inclusive index range.
// ----------------------------------------------------------------------------
// Usage
// - item channel: item_valid/item_ready with operation, position, range_end
//   and new_value; a set beat gives no result, a query beat gives one
// - result channel: result_valid/result_ready with range_sum
// - the front end handles one beat at a time: capture, reciprocal
//   multiply, quotient, then a push that waits while the 2-entry command queue is full
// - the back end runs one command at a time: a set goes through pop, read
//   and write; a query goes through pop, a walk of S memory reads, one per
//   cycle, then drain and output, where S is at most
//   2*(BLOCK_SIZE-1) + TABLE_DEPTH/BLOCK_SIZE - 2, 92 at the defaults
// - an empty query goes from pop straight to output in the back end and returns 0
// - after reset both memories are cleared by a sweep over all TABLE_DEPTH entries
//   (1024 at the defaults); item_ready stays low until the sweep is done
// - a finished sum waits in the output register while the receiver stalls;
//   sets keep executing meanwhile, the next query waits for that register
// ----------------------------------------------------------------------------
module block_range_sum_table #(
    parameter int TABLE_DEPTH = brst_pkg::DEF_TABLE_DEPTH,
    parameter int BLOCK_SIZE  = brst_pkg::DEF_BLOCK_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                operation,
    input  logic [brst_pkg::POS_W-1:0]          position,
    input  logic [brst_pkg::POS_W-1:0]          range_end,
    input  logic signed [brst_pkg::VAL_W-1:0]   new_value,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [brst_pkg::SUM_W-1:0]   range_sum
);

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int NUM_BLOCKS = (TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OFF_W      = $clog2(BLOCK_SIZE);

    logic                        clear_done;

    // front to queue
    logic                        push_valid, push_ready;
    brst_pkg::cmd_ctl_t          push_ctl;
    logic [IDX_W-1:0]            push_idx, push_hi;
    logic [BLK_W-1:0]            push_blk;
    logic [OFF_W-1:0]            push_off;
    logic signed [brst_pkg::VAL_W-1:0] push_value;

    // queue to back
    logic                        pop_valid, pop_ready;
    brst_pkg::cmd_ctl_t          pop_ctl;
    logic [IDX_W-1:0]            pop_idx, pop_hi;
    logic [BLK_W-1:0]            pop_blk;
    logic [OFF_W-1:0]            pop_off;
    logic signed [brst_pkg::VAL_W-1:0] pop_value;

    // input classification
    brst_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .BLOCK_SIZE  (BLOCK_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (clear_done),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .operation  (operation),
        .position   (position),
        .range_end  (range_end),
        .new_value  (new_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctl   (push_ctl),
        .push_idx   (push_idx),
        .push_hi    (push_hi),
        .push_blk   (push_blk),
        .push_off   (push_off),
        .push_value (push_value)
    );

    // command queue
    brst_queue #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .BLOCK_SIZE  (BLOCK_SIZE)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctl   (push_ctl),
        .push_idx   (push_idx),
        .push_hi    (push_hi),
        .push_blk   (push_blk),
        .push_off   (push_off),
        .push_value (push_value),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_ctl    (pop_ctl),
        .pop_idx    (pop_idx),
        .pop_hi     (pop_hi),
        .pop_blk    (pop_blk),
        .pop_off    (pop_off),
        .pop_value  (pop_value)
    );

    // execution and storage
    brst_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .BLOCK_SIZE  (BLOCK_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear_done   (clear_done),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_ctl      (pop_ctl),
        .pop_idx      (pop_idx),
        .pop_hi       (pop_hi),
        .pop_blk      (pop_blk),
        .pop_off      (pop_off),
        .pop_value    (pop_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .range_sum    (range_sum)
    );

endmodule
